[rtl/smcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcf_pkg
// Types and codes shared by the service-message connection engine.
// ----------------------------------------------------------------------------
package smcf_pkg;

  localparam int unsigned CONNECTIONS_DEF = 256;

  // Event kinds.
  localparam logic [2:0] K_REGULATION = 3'd0;
  localparam logic [2:0] K_HOST_MSG   = 3'd1;
  localparam logic [2:0] K_TERM_BLK   = 3'd2;
  localparam logic [2:0] K_LOCAL_DISC = 3'd3;
  localparam logic [2:0] K_CONN_REQ   = 3'd4;
  localparam logic [2:0] K_RESET      = 3'd5;

  // Action codes.
  localparam logic [3:0] A_NONE         = 4'd0;
  localparam logic [3:0] A_LINK_REG     = 4'd1;
  localparam logic [3:0] A_SUPV_REQ     = 4'd2;
  localparam logic [3:0] A_NPU_STATUS   = 4'd3;
  localparam logic [3:0] A_FORWARD      = 4'd4;
  localparam logic [3:0] A_TERM_BLK     = 4'd5;
  localparam logic [3:0] A_DISC_REPLY   = 4'd6;
  localparam logic [3:0] A_DISC_REQ     = 4'd7;
  localparam logic [3:0] A_CONNECTED    = 4'd8;
  localparam logic [3:0] A_DISCONNECTED = 4'd9;
  localparam logic [3:0] A_REJECTED     = 4'd10;
  localparam logic [3:0] A_CLOSE_PORT   = 4'd11;
  localparam logic [3:0] A_CFG_REPLY    = 4'd12;
  localparam logic [3:0] A_RELOAD       = 4'd13;

  // Error codes.
  localparam logic [2:0] E_OK         = 3'd0;
  localparam logic [2:0] E_SHORT      = 3'd1;
  localparam logic [2:0] E_HDR_CONN   = 3'd2;
  localparam logic [2:0] E_NO_P3      = 3'd3;
  localparam logic [2:0] E_UNK_CONN   = 3'd4;
  localparam logic [2:0] E_UNEXPECTED = 3'd5;
  localparam logic [2:0] E_WRONG_ST   = 3'd6;
  localparam logic [2:0] E_UNRECOG    = 3'd7;

  // Supervision states.
  localparam logic [1:0] SV_IDLE  = 2'd0;
  localparam logic [1:0] SV_WAIT  = 2'd1;
  localparam logic [1:0] SV_READY = 2'd2;

  // Connection states.
  localparam logic [2:0] CS_IDLE      = 3'd0;
  localparam logic [2:0] CS_REQ       = 3'd1;
  localparam logic [2:0] CS_CONNECTED = 3'd2;
  localparam logic [2:0] CS_LOC_DISC  = 3'd3;
  localparam logic [2:0] CS_HOST_DISC = 3'd4;

  // Primary and secondary function codes.
  localparam logic [7:0] PFC_SUPERVISE = 8'h0E;
  localparam logic [7:0] PFC_NPU_STAT  = 8'h12;
  localparam logic [7:0] PFC_CONFIGURE = 8'h0F;
  localparam logic [7:0] PFC_INIT_CONN = 8'h02;
  localparam logic [7:0] PFC_TERM_CONN = 8'h03;
  localparam logic [7:0] PFC_RELOAD    = 8'h1E;
  localparam logic [5:0] SFC_SUPERVISE = 6'h0A;
  localparam logic [5:0] SFC_NPU_STAT  = 6'h00;
  localparam logic [5:0] SFC_CONN      = 6'h03;
  localparam logic [5:0] SFC_TERM      = 6'h08;

  localparam logic [7:0] LVL_CS_BIT = 8'h04;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] reg_level;
    logic [7:0] msg_length;
    logic [7:0] header_conn;
    logic [7:0] primary_code;
    logic [5:0] secondary_code;
    logic       resp_flag;
    logic       err_flag;
    logic [7:0] param_p3;
    logic [7:0] term_conn;
  } smcf_in_t;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] target;
    logic [7:0] level_out;
    logic [2:0] error_code;
    logic       ready_res;
    logic       last;
  } smcf_out_t;

endpackage

[rtl/smcf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smcf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/service_message_connection_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// service_message_connection_fsm
// Front-end engine for a host service-message link: supervision state,
// regulation level and a per-connection state table held in RAM.
// ----------------------------------------------------------------------------
//  Channel   Ports                    Handshake
//  input     start, busy, in_data     taken when start && !busy
//  result    out_valid, out_data      one-cycle strobe, cannot be held off
//
// The connection table is read on acceptance and the entry is written back
// in the next cycle, which also registers the first result. An item with
// two results passes through a second emit state before it is done.
// Reset is synchronous; per-entry valid flags make the whole table read as
// idle at once, so there is no clearing pass.
// Results appear in the cycle after they are computed and are never stalled.
module service_message_connection_fsm
  import smcf_pkg::*;
#(
  parameter int unsigned CONNECTIONS = CONNECTIONS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  smcf_in_t  in_data,
  output logic      out_valid,
  output smcf_out_t out_data
);

  localparam int unsigned IDX_W = $clog2(CONNECTIONS);
  localparam logic [8:0]  CONN_LIM = 9'(CONNECTIONS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_EMIT2 = 2'd2;

  logic [1:0]       state_r, state_nxt;
  smcf_in_t         in_r;
  logic [7:0]       conn_r;
  logic [1:0]       sup_r, sup_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic [CONNECTIONS-1:0] vld_r;
  logic             out_valid_r;
  smcf_out_t        out_r, out_nxt;
  logic [3:0]       act2_r;
  logic [7:0]       tgt2_r;
  logic             rdy2_r;

  logic             accept;
  logic [7:0]       conn_sel;
  logic [IDX_W-1:0] idx;
  logic [2:0]       rd_data;
  logic [2:0]       cur;
  logic             conn_ok;

  // Results of the execute cycle.
  logic [3:0]       act1;
  logic [7:0]       tgt1;
  logic [7:0]       lvl1;
  logic [2:0]       err1;
  logic             two_res;
  logic [3:0]       act2;
  logic [7:0]       tgt2;
  logic             we;
  logic [2:0]       wdata;

  logic             idle_sv, plain, resp, errr;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign conn_sel = (in_data.kind == K_HOST_MSG) ? in_data.param_p3 : in_data.term_conn;
  assign idx      = conn_r[IDX_W-1:0];
  assign conn_ok  = (conn_r != 8'd0) && ({1'b0, conn_r} < CONN_LIM);
  // An entry never written since reset reads as idle.
  assign cur      = vld_r[idx] ? rd_data : CS_IDLE;

  smcf_ram #(
    .WIDTH (3),
    .DEPTH (CONNECTIONS)
  ) u_conn_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (idx),
    .wr_data (wdata),
    .re      (accept),
    .rd_addr (conn_sel[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign idle_sv = (sup_r == SV_IDLE);
  assign plain   = !in_r.resp_flag && !in_r.err_flag;
  assign resp    =  in_r.resp_flag && !in_r.err_flag;
  assign errr    = !in_r.resp_flag &&  in_r.err_flag;

  always_comb begin
    act1     = A_NONE;
    tgt1     = 8'd0;
    lvl1     = 8'd0;
    err1     = E_OK;
    two_res  = 1'b0;
    act2     = A_NONE;
    tgt2     = 8'd0;
    we       = 1'b0;
    wdata    = CS_IDLE;
    sup_nxt  = sup_r;
    prev_nxt = prev_r;
    if (state_r == ST_EXEC) begin
      case (in_r.kind)
        K_REGULATION: begin
          if (idle_sv || in_r.reg_level != prev_r) begin
            prev_nxt = in_r.reg_level;
            act1     = A_LINK_REG;
            lvl1     = in_r.reg_level;
            if (idle_sv && (in_r.reg_level & LVL_CS_BIT) != 8'd0) begin
              two_res = 1'b1;
              act2    = A_SUPV_REQ;
            end
          end else if (idle_sv && (in_r.reg_level & LVL_CS_BIT) != 8'd0) begin
            act1 = A_SUPV_REQ;
          end
          if (idle_sv && (in_r.reg_level & LVL_CS_BIT) != 8'd0) begin
            sup_nxt = SV_WAIT;
          end
        end
        K_HOST_MSG: begin
          if (in_r.msg_length < 8'd6) begin
            if (in_r.msg_length == 8'd4 && in_r.header_conn != 8'd0) begin
              act1 = A_FORWARD;
              tgt1 = in_r.header_conn;
            end else begin
              err1 = E_SHORT;
            end
          end else if (in_r.header_conn != 8'd0) begin
            err1 = E_HDR_CONN;
          end else if ((in_r.primary_code inside {PFC_INIT_CONN, PFC_TERM_CONN,
                        PFC_CONFIGURE}) && in_r.msg_length < 8'd7) begin
            err1 = E_NO_P3;
          end else if ((in_r.primary_code inside {PFC_INIT_CONN, PFC_TERM_CONN})
                       && !conn_ok) begin
            err1 = E_UNK_CONN;
          end else begin
            case (in_r.primary_code)
              PFC_SUPERVISE: begin
                if (in_r.secondary_code == SFC_SUPERVISE && resp) begin
                  if (sup_r != SV_WAIT) begin
                    err1 = E_WRONG_ST;
                  end else begin
                    sup_nxt = SV_READY;
                  end
                end else begin
                  err1 = E_UNEXPECTED;
                end
              end
              PFC_NPU_STAT: begin
                if (in_r.secondary_code == SFC_NPU_STAT && plain) begin
                  act1 = A_NPU_STATUS;
                end else begin
                  err1 = E_UNEXPECTED;
                end
              end
              PFC_CONFIGURE: begin
                tgt1 = in_r.param_p3;
                if (in_r.secondary_code == SFC_CONN && resp) begin
                  act1 = A_CFG_REPLY;
                end else if (in_r.secondary_code == SFC_CONN && errr) begin
                  act1 = A_CLOSE_PORT;
                end else begin
                  act1 = A_CLOSE_PORT;
                  err1 = E_UNEXPECTED;
                end
              end
              PFC_INIT_CONN: begin
                tgt1 = in_r.param_p3;
                if (cur != CS_REQ) begin
                  err1 = E_WRONG_ST;
                end else if (in_r.secondary_code == SFC_CONN && resp) begin
                  we    = 1'b1;
                  wdata = CS_CONNECTED;
                  act1  = A_CONNECTED;
                end else if (in_r.secondary_code == SFC_CONN && errr) begin
                  we    = 1'b1;
                  wdata = CS_IDLE;
                  act1  = A_REJECTED;
                end else begin
                  we    = 1'b1;
                  wdata = CS_IDLE;
                  act1  = A_DISCONNECTED;
                  err1  = E_UNEXPECTED;
                end
              end
              PFC_TERM_CONN: begin
                tgt1 = in_r.param_p3;
                if (in_r.secondary_code == SFC_TERM && plain) begin
                  if (cur == CS_CONNECTED) begin
                    we    = 1'b1;
                    wdata = CS_HOST_DISC;
                    act1  = A_TERM_BLK;
                  end else begin
                    act1 = A_DISC_REPLY;
                  end
                end else if (in_r.secondary_code == SFC_TERM && resp) begin
                  if (cur == CS_LOC_DISC) begin
                    we    = 1'b1;
                    wdata = CS_IDLE;
                    act1  = A_DISCONNECTED;
                  end else begin
                    err1 = E_WRONG_ST;
                  end
                end else begin
                  err1 = E_UNEXPECTED;
                end
              end
              PFC_RELOAD: begin
                act1 = A_RELOAD;
              end
              default: begin
                err1 = E_UNRECOG;
              end
            endcase
          end
        end
        K_TERM_BLK: begin
          if (!conn_ok) begin
            err1 = E_UNK_CONN;
          end else if (cur == CS_HOST_DISC) begin
            we      = 1'b1;
            wdata   = CS_IDLE;
            act1    = A_DISC_REPLY;
            tgt1    = conn_r;
            two_res = 1'b1;
            act2    = A_DISCONNECTED;
            tgt2    = conn_r;
          end else if (cur == CS_LOC_DISC) begin
            act1 = A_TERM_BLK;
            tgt1 = conn_r;
          end else begin
            tgt1 = conn_r;
            err1 = E_WRONG_ST;
          end
        end
        K_LOCAL_DISC: begin
          if (!conn_ok) begin
            err1 = E_UNK_CONN;
          end else if (cur == CS_CONNECTED) begin
            we    = 1'b1;
            wdata = CS_LOC_DISC;
            act1  = A_DISC_REQ;
            tgt1  = conn_r;
          end else begin
            tgt1 = conn_r;
            err1 = E_WRONG_ST;
          end
        end
        K_CONN_REQ: begin
          if (!conn_ok) begin
            err1 = E_UNK_CONN;
          end else begin
            we    = 1'b1;
            wdata = CS_REQ;
            tgt1  = conn_r;
          end
        end
        K_RESET: begin
          sup_nxt  = SV_IDLE;
          prev_nxt = 8'd0;
        end
        default: begin
          err1 = E_UNRECOG;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_nxt   = out_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_nxt.action     = act1;
        out_nxt.target     = tgt1;
        out_nxt.level_out  = lvl1;
        out_nxt.error_code = err1;
        out_nxt.ready_res  = (sup_nxt == SV_READY);
        out_nxt.last       = !two_res;
        state_nxt          = two_res ? ST_EMIT2 : ST_IDLE;
      end
      ST_EMIT2: begin
        out_nxt.action     = act2_r;
        out_nxt.target     = tgt2_r;
        out_nxt.level_out  = 8'd0;
        out_nxt.error_code = E_OK;
        out_nxt.ready_res  = rdy2_r;
        out_nxt.last       = 1'b1;
        state_nxt          = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sup_r       <= SV_IDLE;
      prev_r      <= 8'd0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sup_r       <= sup_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= (state_r == ST_EXEC) || (state_r == ST_EMIT2);
      if (we) begin
        vld_r[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      in_r   <= in_data;
      conn_r <= conn_sel;
    end
    if (state_r == ST_EXEC) begin
      act2_r <= act2;
      tgt2_r <= tgt2;
      rdy2_r <= (sup_nxt == SV_READY);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EXEC)
    else $error("accepted item did not enter execute");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_EXEC || $past(state_r) == ST_EMIT2)
    else $error("result strobe without execute or second emit");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid && out_data.last)
    else $error("first of two results not followed by the last one");

  a_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> state_r == ST_EXEC && conn_ok)
    else $error("table write outside execute or to invalid connection");

endmodule

[tb/service_message_connection_fsm_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// service_message_connection_fsm_test
// Self-checking bench for the service-message connection engine. A directed
// sequence and a stream of connection life-cycle items are sent through the
// command port. An in-bench predictor of the supervision state, regulation
// level and connection table computes the results that each item must cause.
// Every result is checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module service_message_connection_fsm_test;
  import smcf_pkg::*;

  localparam int unsigned CONN_COUNT  = CONNECTIONS_DEF;
  localparam int          RANDOM_ITEMS = 290;
  localparam int          TAIL_CYCLES  = 6;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          MAX_REPORTS  = 10;

  // Message lengths that decide the checks on a host message.
  localparam logic [7:0] LEN_MIN     = 8'd6;
  localparam logic [7:0] LEN_FORWARD = 8'd4;
  localparam logic [7:0] LEN_WITH_P3 = 8'd7;

  localparam logic [2:0] K_UNUSED    = 3'd7;
  localparam logic [7:0] PFC_UNKNOWN = 8'hFF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  smcf_in_t  in_data = '0;
  logic      out_valid;
  smcf_out_t out_data;

  smcf_in_t  pending_items[$];
  smcf_out_t expected_results[$];

  // Predicted engine state.
  logic [1:0] supv_st;
  logic [7:0] last_level;
  logic [2:0] conn_tbl[CONN_COUNT];

  int  sender_idle_pct = 0;
  bit  item_taken = 1'b0;
  int  mismatch_count = 0;
  int  stall_cycles = 0;

  service_message_connection_fsm i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit conn_valid(logic [7:0] c);
    return c != 8'd0 && c < CONN_COUNT;
  endfunction

  function automatic smcf_out_t result_item(logic [3:0] act, logic [7:0] tgt,
                                            logic [7:0] lvl, logic [2:0] err);
    smcf_out_t r;
    r = '0;
    r.action     = act;
    r.target     = tgt;
    r.level_out  = lvl;
    r.error_code = err;
    return r;
  endfunction

  // A host message always gives exactly one result.
  function automatic smcf_out_t host_message_result(smcf_in_t it);
    logic [7:0] len;
    logic [7:0] hcn;
    logic [7:0] pfc;
    logic [5:0] sfc;
    logic [7:0] p3;
    bit         plain;
    bit         resp;
    bit         errr;
    len   = it.msg_length;
    hcn   = it.header_conn;
    pfc   = it.primary_code;
    sfc   = it.secondary_code;
    p3    = it.param_p3;
    plain = !it.resp_flag && !it.err_flag;
    resp  = it.resp_flag && !it.err_flag;
    errr  = !it.resp_flag && it.err_flag;
    if (len < LEN_MIN) begin
      if (len == LEN_FORWARD && hcn != 8'd0) return result_item(A_FORWARD, hcn, 8'd0, E_OK);
      return result_item(A_NONE, 8'd0, 8'd0, E_SHORT);
    end
    if (hcn != 8'd0) return result_item(A_NONE, 8'd0, 8'd0, E_HDR_CONN);
    if (pfc == PFC_INIT_CONN || pfc == PFC_TERM_CONN || pfc == PFC_CONFIGURE) begin
      if (len < LEN_WITH_P3) return result_item(A_NONE, 8'd0, 8'd0, E_NO_P3);
      if (pfc != PFC_CONFIGURE && !conn_valid(p3))
        return result_item(A_NONE, 8'd0, 8'd0, E_UNK_CONN);
    end
    case (pfc)
      PFC_SUPERVISE: begin
        if (!(sfc == SFC_SUPERVISE && resp)) return result_item(A_NONE, 8'd0, 8'd0, E_UNEXPECTED);
        if (supv_st != SV_WAIT) return result_item(A_NONE, 8'd0, 8'd0, E_WRONG_ST);
        supv_st = SV_READY;
        return result_item(A_NONE, 8'd0, 8'd0, E_OK);
      end
      PFC_NPU_STAT: begin
        if (sfc == SFC_NPU_STAT && plain) return result_item(A_NPU_STATUS, 8'd0, 8'd0, E_OK);
        return result_item(A_NONE, 8'd0, 8'd0, E_UNEXPECTED);
      end
      PFC_CONFIGURE: begin
        if (sfc == SFC_CONN && resp) return result_item(A_CFG_REPLY, p3, 8'd0, E_OK);
        if (sfc == SFC_CONN && errr) return result_item(A_CLOSE_PORT, p3, 8'd0, E_OK);
        return result_item(A_CLOSE_PORT, p3, 8'd0, E_UNEXPECTED);
      end
      PFC_INIT_CONN: begin
        if (conn_tbl[p3] != CS_REQ) return result_item(A_NONE, p3, 8'd0, E_WRONG_ST);
        if (sfc == SFC_CONN && resp) begin
          conn_tbl[p3] = CS_CONNECTED;
          return result_item(A_CONNECTED, p3, 8'd0, E_OK);
        end
        conn_tbl[p3] = CS_IDLE;
        if (sfc == SFC_CONN && errr) return result_item(A_REJECTED, p3, 8'd0, E_OK);
        return result_item(A_DISCONNECTED, p3, 8'd0, E_UNEXPECTED);
      end
      PFC_TERM_CONN: begin
        if (sfc == SFC_TERM && plain) begin
          if (conn_tbl[p3] == CS_CONNECTED) begin
            conn_tbl[p3] = CS_HOST_DISC;
            return result_item(A_TERM_BLK, p3, 8'd0, E_OK);
          end
          return result_item(A_DISC_REPLY, p3, 8'd0, E_OK);
        end
        if (sfc == SFC_TERM && resp) begin
          if (conn_tbl[p3] == CS_LOC_DISC) begin
            conn_tbl[p3] = CS_IDLE;
            return result_item(A_DISCONNECTED, p3, 8'd0, E_OK);
          end
          return result_item(A_NONE, p3, 8'd0, E_WRONG_ST);
        end
        return result_item(A_NONE, p3, 8'd0, E_UNEXPECTED);
      end
      PFC_RELOAD: return result_item(A_RELOAD, 8'd0, 8'd0, E_OK);
      default:    return result_item(A_NONE, 8'd0, 8'd0, E_UNRECOG);
    endcase
  endfunction

  // Advances the predicted state by one accepted item and queues its results.
  task automatic predict_results(smcf_in_t it);
    smcf_out_t res[2];
    int        n;
    bit        was_idle;
    logic [7:0] tc;
    n  = 0;
    tc = it.term_conn;
    case (it.kind)
      K_REGULATION: begin
        was_idle = (supv_st == SV_IDLE);
        if (was_idle || it.reg_level != last_level) begin
          last_level = it.reg_level;
          res[n] = result_item(A_LINK_REG, 8'd0, it.reg_level, E_OK);
          n++;
        end
        if (was_idle && (it.reg_level & LVL_CS_BIT) != 8'd0) begin
          supv_st = SV_WAIT;
          res[n] = result_item(A_SUPV_REQ, 8'd0, 8'd0, E_OK);
          n++;
        end
        if (n == 0) begin
          res[n] = result_item(A_NONE, 8'd0, 8'd0, E_OK);
          n++;
        end
      end
      K_HOST_MSG: begin
        res[n] = host_message_result(it);
        n++;
      end
      K_TERM_BLK: begin
        if (!conn_valid(tc)) begin
          res[n] = result_item(A_NONE, 8'd0, 8'd0, E_UNK_CONN);
          n++;
        end else if (conn_tbl[tc] == CS_HOST_DISC) begin
          conn_tbl[tc] = CS_IDLE;
          res[0] = result_item(A_DISC_REPLY, tc, 8'd0, E_OK);
          res[1] = result_item(A_DISCONNECTED, tc, 8'd0, E_OK);
          n = 2;
        end else if (conn_tbl[tc] == CS_LOC_DISC) begin
          res[n] = result_item(A_TERM_BLK, tc, 8'd0, E_OK);
          n++;
        end else begin
          res[n] = result_item(A_NONE, tc, 8'd0, E_WRONG_ST);
          n++;
        end
      end
      K_LOCAL_DISC: begin
        if (!conn_valid(tc)) begin
          res[n] = result_item(A_NONE, 8'd0, 8'd0, E_UNK_CONN);
        end else if (conn_tbl[tc] == CS_CONNECTED) begin
          conn_tbl[tc] = CS_LOC_DISC;
          res[n] = result_item(A_DISC_REQ, tc, 8'd0, E_OK);
        end else begin
          res[n] = result_item(A_NONE, tc, 8'd0, E_WRONG_ST);
        end
        n++;
      end
      K_CONN_REQ: begin
        if (!conn_valid(tc)) begin
          res[n] = result_item(A_NONE, 8'd0, 8'd0, E_UNK_CONN);
        end else begin
          conn_tbl[tc] = CS_REQ;
          res[n] = result_item(A_NONE, tc, 8'd0, E_OK);
        end
        n++;
      end
      K_RESET: begin
        supv_st    = SV_IDLE;
        last_level = 8'd0;
        res[n] = result_item(A_NONE, 8'd0, 8'd0, E_OK);
        n++;
      end
      default: begin
        res[n] = result_item(A_NONE, 8'd0, 8'd0, E_UNRECOG);
        n++;
      end
    endcase
    for (int k = 0; k < n; k++) begin
      res[k].ready_res = (supv_st == SV_READY);
      res[k].last      = (k == n - 1);
      expected_results.push_back(res[k]);
    end
  endtask

  function automatic smcf_in_t random_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(smcf_in_t)-1:0];
  endfunction

  function automatic smcf_in_t reg_item(logic [7:0] lvl);
    smcf_in_t it;
    it = random_item();
    it.kind      = K_REGULATION;
    it.reg_level = lvl;
    return it;
  endfunction

  function automatic smcf_in_t conn_item(logic [2:0] kind, logic [7:0] c);
    smcf_in_t it;
    it = random_item();
    it.kind      = kind;
    it.term_conn = c;
    return it;
  endfunction

  function automatic smcf_in_t host_item(logic [7:0] len, logic [7:0] hcn, logic [7:0] pfc,
                                         logic [5:0] sfc, logic rf, logic ef, logic [7:0] p3);
    smcf_in_t it;
    it = random_item();
    it.kind           = K_HOST_MSG;
    it.msg_length     = len;
    it.header_conn    = hcn;
    it.primary_code   = pfc;
    it.secondary_code = sfc;
    it.resp_flag      = rf;
    it.err_flag       = ef;
    it.param_p3       = p3;
    return it;
  endfunction

  // A small pool of connections lets random items drive each one through
  // its whole life cycle; now and then an invalid number is used.
  function automatic logic [7:0] pick_conn();
    logic [7:0] pool[8];
    pool = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd128, 8'd254, 8'd255};
    if ($urandom_range(15) == 0) return 8'd0;
    return pool[3'($urandom_range(7))];
  endfunction

  function automatic smcf_in_t life_cycle_item();
    logic [7:0] lvls[4];
    int         sel;
    int         fsel;
    logic       rf;
    logic       ef;
    logic [7:0] len;
    smcf_in_t   it;
    lvls = '{8'h00, LVL_CS_BIT, 8'h08, 8'h0C};
    sel  = $urandom_range(99);
    fsel = $urandom_range(9);
    // Replies mostly carry the normal-response flag.
    rf   = (fsel < 7) || (fsel == 9 && $urandom_range(1) == 1);
    ef   = (fsel >= 7 && fsel < 9) || (fsel == 9 && !rf);
    len  = 8'($urandom_range(255, LEN_WITH_P3));
    if (sel < 10) begin
      it = reg_item(($urandom_range(4) == 0) ? 8'($urandom) : lvls[2'($urandom_range(3))]);
    end else if (sel < 22) begin
      it = conn_item(K_CONN_REQ, pick_conn());
    end else if (sel < 36) begin
      it = host_item(len, 8'd0, PFC_INIT_CONN, SFC_CONN, rf, ef, pick_conn());
    end else if (sel < 46) begin
      it = conn_item(K_LOCAL_DISC, pick_conn());
    end else if (sel < 54) begin
      it = host_item(len, 8'd0, PFC_TERM_CONN, SFC_TERM, 1'b0, fsel == 9, pick_conn());
    end else if (sel < 62) begin
      it = host_item(len, 8'd0, PFC_TERM_CONN, SFC_TERM, 1'b1, fsel == 9, pick_conn());
    end else if (sel < 72) begin
      it = conn_item(K_TERM_BLK, pick_conn());
    end else if (sel < 76) begin
      it = host_item(len, 8'd0, PFC_SUPERVISE, SFC_SUPERVISE, rf, ef, 8'($urandom));
    end else if (sel < 82) begin
      case ($urandom_range(3))
        0:       it = host_item(len, 8'd0, PFC_NPU_STAT, SFC_NPU_STAT, !rf, ef, 8'($urandom));
        1:       it = host_item(len, 8'd0, PFC_CONFIGURE, SFC_CONN, rf, ef, 8'($urandom));
        2:       it = host_item(len, 8'd0, PFC_RELOAD, 6'($urandom), rf, ef, 8'($urandom));
        default: it = host_item(len, 8'd0, 8'($urandom), 6'($urandom), rf, ef, 8'($urandom));
      endcase
    end else if (sel < 84) begin
      it = conn_item(K_RESET, 8'($urandom));
    end else if (sel < 92) begin
      // Broken host messages: short, with a header connection, or without P3.
      it = host_item(8'($urandom_range(7)), ($urandom_range(1) == 1) ? 8'($urandom) : 8'd0,
                     8'($urandom_range(3)), SFC_CONN, rf, ef, pick_conn());
    end else begin
      it = random_item();
    end
    return it;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start   <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        start   <= 1'b0;
        in_data <= random_item();
      end
    end
  end

  always @(posedge clk) begin
    smcf_out_t want;
    if (!rst_n) begin
      item_taken = 1'b0;
      supv_st    = SV_IDLE;
      last_level = 8'd0;
      foreach (conn_tbl[i]) conn_tbl[i] = CS_IDLE;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with none expected: action %0d target %0d level %0d err %0d",
                     $realtime, out_data.action, out_data.target, out_data.level_out,
                     out_data.error_code);
        end else begin
          want = expected_results.pop_front();
          if (out_data.action !== want.action || out_data.target !== want.target ||
              out_data.level_out !== want.level_out ||
              out_data.error_code !== want.error_code ||
              out_data.ready_res !== want.ready_res || out_data.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $write("%0t: expected act %0d tgt %0d lvl %0d err %0d rdy %0b last %0b,",
                     $realtime, want.action, want.target, want.level_out, want.error_code,
                     want.ready_res, want.last);
              $display(" got act %0d tgt %0d lvl %0d err %0d rdy %0b last %0b",
                       out_data.action, out_data.target, out_data.level_out,
                       out_data.error_code, out_data.ready_res, out_data.last);
            end
          end
        end
      end
      item_taken = start && !busy;
      if (item_taken) predict_results(in_data);
    end
  end

  // Ends the run when work is outstanding but nothing moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid ||
        (!start && pending_items.size() == 0 && expected_results.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Supervision handshake, regulation levels and message checks.
    pending_items.push_back(reg_item(8'h00));
    pending_items.push_back(reg_item(LVL_CS_BIT));
    pending_items.push_back(reg_item(LVL_CS_BIT));
    pending_items.push_back(host_item(LEN_MIN, 8'd0, PFC_SUPERVISE, SFC_SUPERVISE,
                                      1'b1, 1'b0, 8'd0));
    pending_items.push_back(reg_item(8'hFF));
    pending_items.push_back(host_item(8'd0, 8'd0, PFC_NPU_STAT, SFC_NPU_STAT, 1'b0, 1'b0, 8'd0));
    pending_items.push_back(host_item(LEN_FORWARD, 8'h80, PFC_RELOAD, 6'h3F, 1'b1, 1'b1, 8'd0));
    pending_items.push_back(host_item(8'd5, 8'd0, PFC_RELOAD, 6'd0, 1'b0, 1'b0, 8'd0));
    pending_items.push_back(host_item(LEN_MIN, 8'hFF, PFC_RELOAD, 6'd0, 1'b0, 1'b0, 8'd0));
    pending_items.push_back(host_item(LEN_MIN, 8'd0, PFC_INIT_CONN, SFC_CONN,
                                      1'b1, 1'b0, 8'd255));
    pending_items.push_back(host_item(LEN_WITH_P3, 8'd0, PFC_INIT_CONN, SFC_CONN,
                                      1'b1, 1'b0, 8'd0));
    // Local disconnect path on the highest connection.
    pending_items.push_back(conn_item(K_CONN_REQ, 8'd0));
    pending_items.push_back(conn_item(K_CONN_REQ, 8'd255));
    pending_items.push_back(host_item(8'd255, 8'd0, PFC_INIT_CONN, SFC_CONN,
                                      1'b1, 1'b0, 8'd255));
    pending_items.push_back(conn_item(K_LOCAL_DISC, 8'd255));
    pending_items.push_back(conn_item(K_TERM_BLK, 8'd255));
    pending_items.push_back(host_item(LEN_WITH_P3, 8'd0, PFC_TERM_CONN, SFC_TERM,
                                      1'b1, 1'b0, 8'd255));
    // Host disconnect path: the TERM block gives two results.
    pending_items.push_back(conn_item(K_CONN_REQ, 8'd1));
    pending_items.push_back(host_item(LEN_WITH_P3, 8'd0, PFC_INIT_CONN, SFC_CONN,
                                      1'b1, 1'b0, 8'd1));
    pending_items.push_back(host_item(LEN_WITH_P3, 8'd0, PFC_TERM_CONN, SFC_TERM,
                                      1'b0, 1'b0, 8'd1));
    pending_items.push_back(conn_item(K_TERM_BLK, 8'd1));
    // Remaining message types, unknown codes and the reset event.
    pending_items.push_back(host_item(LEN_WITH_P3, 8'd0, PFC_NPU_STAT, SFC_NPU_STAT,
                                      1'b0, 1'b0, 8'd0));
    pending_items.push_back(host_item(LEN_WITH_P3, 8'd0, PFC_CONFIGURE, SFC_CONN,
                                      1'b0, 1'b1, 8'h3F));
    pending_items.push_back(host_item(LEN_WITH_P3, 8'd0, PFC_UNKNOWN, 6'd0, 1'b0, 1'b0, 8'd0));
    pending_items.push_back(conn_item(K_UNUSED, 8'd0));
    pending_items.push_back(conn_item(K_RESET, 8'd0));

    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 69 : 0;
      repeat (RANDOM_ITEMS) pending_items.push_back(life_cycle_item());
      // The sender stays quiet until every outstanding result is back.
      while (pending_items.size() != 0 || start || expected_results.size() != 0)
        @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
